/* design/ierf_pkg.sv */
// ----------------------------------------------------------------------------
// ierf_pkg
// shared types, constants and coefficient tables of the inverse erf pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package ierf_pkg;

  localparam int IN_FRAC_BITS_DEF  = 24;
  localparam int OUT_FRAC_BITS_DEF = 20;

  localparam int ARG_W = 25;
  localparam int VAL_W = 23;
  localparam int P_W   = 36;
  localparam int V_W   = 36;
  localparam int W_W   = 35;

  localparam int NORM_STAGES = 6;
  localparam int LOG_STAGES  = 30;
  localparam int SQRT_STAGES = 32;
  localparam int HORN_STAGES = 8;

  localparam logic [31:0] CLAMP_Q32 = 32'd4294924346;
  localparam logic [27:0] LN2_Q28   = 28'd186065280;

  typedef struct packed {
    logic            neg;
    logic [31:0]     a;
    logic [W_W-1:0]  w;
  } ierf_side_t;

  function automatic logic signed [P_W-1:0] coef(input logic tail, input logic [3:0] idx);
    logic signed [P_W-1:0] c;
    c = '0;
    if (!tail) begin
      case (idx)
        4'd0:    c = 36'sd30;
        4'd1:    c = 36'sd369;
        4'd2:    c = -36'sd3783;
        4'd3:    c = -36'sd4715;
        4'd4:    c = 36'sd234699;
        4'd5:    c = -36'sd1346177;
        4'd6:    c = -36'sd4485752;
        4'd7:    c = 36'sd264828464;
        4'd8:    c = 36'sd1612126078;
        default: c = '0;
      endcase
    end else begin
      case (idx)
        4'd0:    c = -36'sd214978;
        4'd1:    c = 36'sd108395;
        4'd2:    c = 36'sd1448846;
        4'd3:    c = -36'sd3944314;
        4'd4:    c = 36'sd6162749;
        4'd5:    c = -36'sd8184555;
        4'd6:    c = 36'sd10134910;
        4'd7:    c = 36'sd1075539332;
        4'd8:    c = 36'sd3041885698;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/ierf_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// ierf_sqrt_pipe
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module ierf_sqrt_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic [63:0]        n_i,
  input  wire ierf_pkg::ierf_side_t side_i,
  output logic                    vld_o,
  output logic [31:0]             root_o,
  output ierf_pkg::ierf_side_t    side_o
);

  localparam int N = ierf_pkg::SQRT_STAGES;

  logic                 v_q    [N];
  logic [63:0]          n_q    [N];
  logic [63:0]          r_q    [N];
  ierf_pkg::ierf_side_t s_q    [N];
  logic [63:0]          n_d    [N];
  logic [63:0]          r_d    [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [63:0] n_in;
      logic [63:0] r_in;
      logic [63:0] bt;
      n_in = (i == 0) ? n_i : n_q[(i == 0) ? 0 : i-1];
      r_in = (i == 0) ? 64'd0 : r_q[(i == 0) ? 0 : i-1];
      bt   = 64'd1 << (62 - 2*i);
      if (n_in >= r_in + bt) begin
        n_d[i] = n_in - (r_in + bt);
        r_d[i] = (r_in >> 1) + bt;
      end else begin
        n_d[i] = n_in;
        r_d[i] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= vld_i;
      for (int i = 1; i < N; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= side_i;
      for (int i = 1; i < N; i++) s_q[i] <= s_q[i-1];
      for (int i = 0; i < N; i++) begin
        n_q[i] <= n_d[i];
        r_q[i] <= r_d[i];
      end
    end
  end

  assign vld_o  = v_q[N-1];
  assign root_o = r_q[N-1][31:0];
  assign side_o = s_q[N-1];

endmodule

`default_nettype wire

/* design/inverse_error_function.sv */
// ----------------------------------------------------------------------------
// inverse_error_function
// erfinv of a fixed-point argument, fully pipelined
// ----------------------------------------------------------------------------
//   channel  | dir | handshake                    | payload
//   arg      | in  | arg_valid_i / arg_stall_o     | arg_i     (s25)
//   value    | out | value_valid_o / value_stall_i | value_o   (s23)
//
// one beat per cycle while the output is not stalled; the pipe has 6 normalize
// stages, 30 log2 squaring stages, 32 square root stages and 8 horner multiplies
// the whole pipe holds while a finished beat is stalled at the output;
// bubbles hold with it
// reset clears only the valid bits
`default_nettype none

module inverse_error_function #(
  parameter int IN_FRAC_BITS  = ierf_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = ierf_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                arg_valid_i,
  output logic                                     arg_stall_o,
  input  wire logic signed [ierf_pkg::ARG_W-1:0]   arg_i,
  output logic                                     value_valid_o,
  input  wire logic                                value_stall_i,
  output logic signed [ierf_pkg::VAL_W-1:0]        value_o
);

  localparam int SHL = 32 - IN_FRAC_BITS;
  localparam int SH  = 62 - OUT_FRAC_BITS;
  localparam int NN  = ierf_pkg::NORM_STAGES;
  localparam int NL  = ierf_pkg::LOG_STAGES;
  localparam int NH  = ierf_pkg::HORN_STAGES;
  localparam int PW  = ierf_pkg::P_W;
  localparam int VW  = ierf_pkg::V_W;
  localparam int WW  = ierf_pkg::W_W;
  localparam int AW  = ierf_pkg::ARG_W;
  localparam int OW  = ierf_pkg::VAL_W;

  logic adv;
  assign adv         = !(value_valid_o && value_stall_i);
  assign arg_stall_o = !adv;

  // stage 1: magnitude and clamp
  logic [AW-1:0]      mag;
  logic [AW+31:0]     a_wide;
  logic [31:0]        a_d;
  logic               v1_q;
  ierf_pkg::ierf_side_t s1_q;

  always_comb begin
    mag    = arg_i[AW-1] ? (AW'(0) - arg_i) : arg_i;
    a_wide = {32'd0, mag} << SHL;
    a_d    = (a_wide > (AW+32)'(ierf_pkg::CLAMP_Q32)) ? ierf_pkg::CLAMP_Q32 : a_wide[31:0];
  end

  // stage 2: t = 1 - a^2
  logic               v2_q;
  logic [63:0]        t2_q;
  logic               z2_q;
  ierf_pkg::ierf_side_t s2_q;

  // normalize
  logic               nv_q [NN];
  logic [63:0]        nt_q [NN];
  logic [6:0]         nk_q [NN];
  logic               nz_q [NN];
  ierf_pkg::ierf_side_t ns_q [NN];
  logic [63:0]        nt_d [NN];
  logic [6:0]         nk_d [NN];

  always_comb begin
    for (int j = 0; j < NN; j++) begin
      logic [63:0] ti;
      logic [6:0]  ki;
      int          n;
      ti = (j == 0) ? t2_q : nt_q[(j == 0) ? 0 : j-1];
      ki = (j == 0) ? 7'd0 : nk_q[(j == 0) ? 0 : j-1];
      n  = 32 >> j;
      if ((ti >> (64 - n)) == 64'd0) begin
        nt_d[j] = ti << n;
        nk_d[j] = ki + 7'(n);
      end else begin
        nt_d[j] = ti;
        nk_d[j] = ki;
      end
    end
  end

  // log2 by repeated squaring
  logic               lv_q [NL];
  logic [31:0]        ly_q [NL];
  logic [29:0]        lf_q [NL];
  logic [6:0]         lk_q [NL];
  logic               lz_q [NL];
  ierf_pkg::ierf_side_t ls_q [NL];
  logic [31:0]        ly_d [NL];
  logic [29:0]        lf_d [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      logic [31:0] yi;
      logic [29:0] fi;
      logic [63:0] sq;
      yi = (i == 0) ? nt_q[NN-1][63:32] : ly_q[(i == 0) ? 0 : i-1];
      fi = (i == 0) ? 30'd0 : lf_q[(i == 0) ? 0 : i-1];
      sq = 64'(yi) * 64'(yi);
      if (sq[63]) begin
        ly_d[i] = sq[63:32];
        lf_d[i] = {fi[28:0], 1'b1};
      end else begin
        ly_d[i] = sq[62:31];
        lf_d[i] = {fi[28:0], 1'b0};
      end
    end
  end

  // w = L * ln2
  logic [36:0]        big_l;
  logic [64:0]        wprod;
  logic [WW-1:0]      w_d;
  logic               wv_q;
  ierf_pkg::ierf_side_t ws_q;

  always_comb begin
    big_l = ((37'(lk_q[NL-1]) + 37'd1) << 30) - 37'(lf_q[NL-1]);
    wprod = 65'(big_l) * 65'(ierf_pkg::LN2_Q28) + (65'd1 << 29);
    w_d   = lz_q[NL-1] ? '0 : WW'(wprod >> 30);
  end

  // square root of w in Q28
  logic               qv;
  logic [31:0]        root;
  ierf_pkg::ierf_side_t qs;

  ierf_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (wv_q),
    .n_i    (64'(ws_q.w) << 28),
    .side_i (ws_q),
    .vld_o  (qv),
    .root_o (root),
    .side_o (qs)
  );

  // horner entry
  logic                 tail_d;
  logic signed [VW-1:0] hv_d;
  logic                 ev_q;
  logic                 et_q;
  logic signed [VW-1:0] ex_q;
  ierf_pkg::ierf_side_t es_q;

  always_comb begin
    tail_d = qs.w >= (WW'(5) << 28);
    if (tail_d) begin
      hv_d = $signed(VW'(root)) - $signed(VW'(3) << 28);
    end else begin
      hv_d = $signed(VW'(qs.w)) - $signed(VW'(5) << 27);
    end
  end

  // horner steps
  logic                 hv_q [NH];
  logic signed [PW-1:0] hp_q [NH];
  logic signed [VW-1:0] hx_q [NH];
  logic                 ht_q [NH];
  ierf_pkg::ierf_side_t hs_q [NH];
  logic signed [PW-1:0] hp_d [NH];

  always_comb begin
    for (int i = 0; i < NH; i++) begin
      logic signed [PW-1:0]    pi;
      logic signed [VW-1:0]    xi;
      logic                    ti;
      logic signed [PW+VW-1:0] pr;
      pi = (i == 0) ? ierf_pkg::coef(et_q, 4'd0) : hp_q[(i == 0) ? 0 : i-1];
      xi = (i == 0) ? ex_q : hx_q[(i == 0) ? 0 : i-1];
      ti = (i == 0) ? et_q : ht_q[(i == 0) ? 0 : i-1];
      pr = (PW+VW)'(pi) * (PW+VW)'(xi) + (PW+VW)'(64'sd1 << 27);
      hp_d[i] = ierf_pkg::coef(ti, 4'(i+1)) + PW'(pr >>> 28);
    end
  end

  // scale by |x|
  logic [PW-2:0]      pc;
  logic               fv_q;
  logic [PW+30:0]     fprod_q;
  logic               fneg_q;

  assign pc = hp_q[NH-1][PW-1] ? '0 : hp_q[NH-1][PW-2:0];

  // round, saturate, sign
  logic [PW+31:0]     rsum;
  logic [PW+31:0]     res;
  logic [PW+31:0]     lim;
  logic [OW-1:0]      mag_o;

  always_comb begin
    rsum  = (PW+32)'(fprod_q) + ((PW+32)'(1) << (SH - 1));
    res   = rsum >> SH;
    lim   = fneg_q ? ((PW+32)'(1) << (OW - 1)) : (((PW+32)'(1) << (OW - 1)) - 1);
    mag_o = (res > lim) ? lim[OW-1:0] : res[OW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int j = 0; j < NN; j++) nv_q[j] <= 1'b0;
      for (int i = 0; i < NL; i++) lv_q[i] <= 1'b0;
      wv_q <= 1'b0;
      ev_q <= 1'b0;
      for (int i = 0; i < NH; i++) hv_q[i] <= 1'b0;
      fv_q <= 1'b0;
      value_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q <= arg_valid_i;
      v2_q <= v1_q;
      nv_q[0] <= v2_q;
      for (int j = 1; j < NN; j++) nv_q[j] <= nv_q[j-1];
      lv_q[0] <= nv_q[NN-1];
      for (int i = 1; i < NL; i++) lv_q[i] <= lv_q[i-1];
      wv_q <= lv_q[NL-1];
      ev_q <= qv;
      hv_q[0] <= ev_q;
      for (int i = 1; i < NH; i++) hv_q[i] <= hv_q[i-1];
      fv_q <= hv_q[NH-1];
      value_valid_o <= fv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.neg <= arg_i[AW-1];
      s1_q.a   <= a_d;
      s1_q.w   <= '0;
      t2_q <= 64'd0 - 64'(s1_q.a) * 64'(s1_q.a);
      z2_q <= (s1_q.a == 32'd0);
      s2_q <= s1_q;
      for (int j = 0; j < NN; j++) begin
        nt_q[j] <= nt_d[j];
        nk_q[j] <= nk_d[j];
        nz_q[j] <= (j == 0) ? z2_q : nz_q[(j == 0) ? 0 : j-1];
        ns_q[j] <= (j == 0) ? s2_q : ns_q[(j == 0) ? 0 : j-1];
      end
      for (int i = 0; i < NL; i++) begin
        ly_q[i] <= ly_d[i];
        lf_q[i] <= lf_d[i];
        lk_q[i] <= (i == 0) ? nk_q[NN-1] : lk_q[(i == 0) ? 0 : i-1];
        lz_q[i] <= (i == 0) ? nz_q[NN-1] : lz_q[(i == 0) ? 0 : i-1];
        ls_q[i] <= (i == 0) ? ns_q[NN-1] : ls_q[(i == 0) ? 0 : i-1];
      end
      ws_q.neg <= ls_q[NL-1].neg;
      ws_q.a   <= ls_q[NL-1].a;
      ws_q.w   <= w_d;
      et_q <= tail_d;
      ex_q <= hv_d;
      es_q <= qs;
      for (int i = 0; i < NH; i++) begin
        hp_q[i] <= hp_d[i];
        hx_q[i] <= (i == 0) ? ex_q : hx_q[(i == 0) ? 0 : i-1];
        ht_q[i] <= (i == 0) ? et_q : ht_q[(i == 0) ? 0 : i-1];
        hs_q[i] <= (i == 0) ? es_q : hs_q[(i == 0) ? 0 : i-1];
      end
      fprod_q <= (PW+31)'(pc) * (PW+31)'(hs_q[NH-1].a);
      fneg_q  <= hs_q[NH-1].neg;
      value_o <= fneg_q ? $signed(OW'(0) - mag_o) : $signed(mag_o);
    end
  end

endmodule

`default_nettype wire

/* design/ierf_checker.sv */
// ----------------------------------------------------------------------------
// ierf_checker
// port-level checks of the inverse erf pipeline, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ierf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              arg_valid_i,
  input wire logic                              arg_stall_o,
  input wire logic signed [ierf_pkg::ARG_W-1:0] arg_i,
  input wire logic                              value_valid_o,
  input wire logic                              value_stall_i,
  input wire logic signed [ierf_pkg::VAL_W-1:0] value_o
);

  // input stalls only behind a stalled output beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arg_stall_o |-> (value_valid_o && value_stall_i))
    else $error("input stalled without a blocked output beat");

  // an empty output never holds back the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !value_valid_o |-> !arg_stall_o)
    else $error("input stalled with empty output");

  // a stalled output beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (value_valid_o && value_stall_i) |=> (value_valid_o && $stable(value_o)))
    else $error("stalled output beat changed");

endmodule

bind inverse_error_function ierf_checker u_ierf_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// checks the inverse erf pipeline against a bit-exact fixed-point predictor;
// directed edge arguments, then random beats under three idling profiles
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY   = 82;
  localparam int LIMIT_CYC = 400000;
  localparam int AW        = ierf_pkg::ARG_W;
  localparam int OW        = ierf_pkg::VAL_W;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic arg_valid_i = 1'b0;
  logic arg_stall_o;
  logic signed [AW-1:0] arg_i = '0;
  logic value_valid_o;
  logic value_stall_i = 1'b0;
  logic signed [OW-1:0] value_o;

  logic [OW-1:0] erfinv_q[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  inverse_error_function u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .arg_valid_i(arg_valid_i), .arg_stall_o(arg_stall_o), .arg_i(arg_i),
    .value_valid_o(value_valid_o), .value_stall_i(value_stall_i),
    .value_o(value_o)
  );

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned neg_ln(longint unsigned a);
    longint unsigned t, y, frac, big_l;
    int k;
    t = 64'd0 - a * a;
    k = 0;
    frac = 0;
    while (t[63] == 1'b0) begin
      t = t << 1;
      k++;
    end
    y = t >> 32;
    for (int i = 0; i < 30; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= (64'd1 << 32)) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    big_l = (longint'(k + 1) << 30) - frac;
    return (big_l * longint'(ierf_pkg::LN2_Q28) + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [OW-1:0] erfinv_fx(logic signed [AW-1:0] x);
    logic neg;
    longint unsigned raw, mag, a, w, res, lim;
    longint p, v;
    logic tail;
    int sh;
    neg = x[AW-1];
    raw = longint'(unsigned'(x));
    mag = neg ? ((64'd1 << AW) - raw) : raw;
    a = mag << (32 - ierf_pkg::IN_FRAC_BITS_DEF);
    sh = 62 - ierf_pkg::OUT_FRAC_BITS_DEF;
    if (a > longint'(ierf_pkg::CLAMP_Q32)) a = longint'(ierf_pkg::CLAMP_Q32);
    w = (a == 0) ? 0 : neg_ln(a);
    tail = (w >= (64'd5 << 28));
    if (!tail) v = longint'(w) - (64'sd5 <<< 27);
    else v = longint'(isqrt(w << 28)) - 3 * (64'sd1 <<< 28);
    p = tail ? -214978 : 30;
    for (int i = 1; i < 9; i++) begin
      p = longint'(ierf_pkg::coef(tail, 4'(i))) + floor_sh(p * v + (64'sd1 <<< 27), 28);
    end
    if (p < 0) p = 0;
    res = (longint'(p) * a + (64'd1 << (sh - 1))) >> sh;
    lim = neg ? (64'd1 << (OW - 1)) : ((64'd1 << (OW - 1)) - 1);
    if (res > lim) res = lim;
    if (neg) res = 64'd0 - res;
    return res[OW-1:0];
  endfunction

  // receiver stall and result check
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("tb_top failed");
      $finish;
    end
    if (rst_ni && value_valid_o && !value_stall_i) begin
      if (erfinv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat value=%0d", value_o);
      end else begin
        logic [OW-1:0] exp_v;
        exp_v = erfinv_q.pop_front();
        if (exp_v !== value_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch value exp=%0d act=%0d", $signed(exp_v), value_o);
        end
      end
    end
    value_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_arg(logic signed [AW-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      arg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    arg_valid_i <= 1'b1;
    arg_i <= x;
    @(posedge clk_i);
    while (arg_stall_o) @(posedge clk_i);
    erfinv_q.push_back(erfinv_fx(x));
  endtask

  function automatic logic signed [AW-1:0] rand_arg();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return AW'($urandom);
    if (sel < 4) return AW'($urandom_range(16777215, 16776000));
    if (sel < 6) return -AW'($urandom_range(16777215, 16776000));
    if (sel < 7) return AW'(int'($urandom_range(200)) - 100);
    if ($urandom_range(1) != 0) return AW'($urandom_range(16777215));
    return -AW'($urandom_range(16777215));
  endfunction

  task automatic test_edges();
    logic signed [AW-1:0] dir_args[$];
    dir_args = {25'sd0, 25'sd1, -25'sd1, 25'sd16777215, -25'sd16777215, 25'h1000000,
                25'sd8388608, -25'sd8388608, 25'sd16777048, 25'sd16777049,
                -25'sd16777049, 25'sd16624000, -25'sd16624000, 25'sd16700000,
                25'sd1000, 25'sd4194304, 25'sd16000000, -25'sd12000000};
    foreach (dir_args[i]) send_arg(dir_args[i]);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) send_arg(rand_arg());
  endtask

  task automatic test_drain_pause();
    arg_valid_i <= 1'b0;
    while (erfinv_q.size() != 0) @(posedge clk_i);
    repeat (5) send_arg(rand_arg());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_random(530, 21, 79);
    test_drain_pause();
    test_random(530, 79, 21);
    test_random(530, 0, 0);
    arg_valid_i <= 1'b0;
    while (erfinv_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
